// ----- src/positional_insert_delete_list_assert.svh -----
// assertion macros for the positional insert/delete list
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PIDL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidl assertion failed");

// next-cycle implication, checked out of reset
`define PIDL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidl assertion failed");

`endif

// ----- src/pidl_pkg.sv -----
// shared types and constants for the positional insert/delete list
package pidl_pkg;

    localparam int DEPTH  = 16;
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic              insert;
        logic              remove;
        logic              clear;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- src/pidl_cell.sv -----
// one list cell: holds an entry, shifts from either neighbor
module pidl_cell (
    input  logic                        clk,
    input  pidl_pkg::cell_cmd_t         cmd,
    input  logic [pidl_pkg::POS_W-1:0]  idx,
    input  logic [pidl_pkg::DATA_W-1:0] left_data,
    input  logic [pidl_pkg::DATA_W-1:0] right_data,
    output logic [pidl_pkg::DATA_W-1:0] data
);
    import pidl_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert)
        begin
            if (idx > cmd.position)
            begin
                data_next = left_data;
            end
            else if (idx == cmd.position)
            begin
                data_next = cmd.value;
            end
        end
        else if (cmd.remove)
        begin
            if (idx >= cmd.position)
            begin
                data_next = right_data;
            end
        end
        else if (cmd.clear)
        begin
            data_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- src/positional_insert_delete_list.sv -----
// top level of the positional insert/delete list
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  s       | s_tvalid/s_tready  | tuser: op; tdata: position, value
//  m       | m_tvalid/m_tready  | tdata: ok, read_value, length, full_res
//  cfg     | cfg_valid/cfg_ready| cfg_data: capacity
//
// one item per cycle while the result is not stalled: every cell shifts in parallel, the length
// counter and output register update in the same cycle
// the result appears in the cycle after accept; the next item is taken in the cycle
// the previous result leaves
// reset clears length, capacity (to 16) and the output valid; entries stay undefined
// a stalled result stalls the input side only while it is held
module positional_insert_delete_list (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // op
    input  logic [39:0] s_tdata,   // position[3:0], value[35:4], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ok[0], read_value[32:1], length[37:33], full_res[38]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // capacity
);
    import pidl_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  cap_eff;
    logic              m_tvalid_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic [CNT_W-1:0]  len_reg;
    logic              full_reg;
    logic              full_next;

    logic              in_acc;
    logic [1:0]        op;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  pos_ext;
    logic [DATA_W-1:0] val;
    logic              ins_ok;
    logic              rem_ok;
    logic              rd_ok;
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] cell_q [DEPTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;

    assign op      = s_tuser;
    assign pos     = s_tdata[POS_W-1:0];
    assign val     = s_tdata[POS_W+DATA_W-1:POS_W];
    assign pos_ext = {{(CNT_W-POS_W){1'b0}}, pos};

    assign cap_eff = (capacity_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_reg;

    assign ins_ok = (count_reg < cap_eff) && (pos_ext <= count_reg);
    assign rem_ok = pos_ext < count_reg;
    assign rd_ok  = pos_ext < count_reg;

    assign cmd.insert   = in_acc && (op == OP_INSERT) && ins_ok;
    assign cmd.remove   = in_acc && (op == OP_REMOVE) && rem_ok;
    assign cmd.clear    = in_acc && (op == OP_CLEAR);
    assign cmd.position = pos;
    assign cmd.value    = val;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = cell_q[gi];
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end
            pidl_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .idx        (POS_W'(gi)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        rd_next    = '0;
        case (op)
            OP_INSERT:
            begin
                if (ins_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (rem_ok)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            OP_READ:
            begin
                if (rd_ok)
                begin
                    rd_next = cell_q[pos];
                    ok_next = 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
        full_next = count_next >= cap_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CNT_W'(16);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (in_acc)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ok_reg   <= ok_next;
            rd_reg   <= rd_next;
            len_reg  <= count_next;
            full_reg <= full_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, full_reg, len_reg, rd_reg, ok_reg};

`include "positional_insert_delete_list_assert.svh"

    `PIDL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `PIDL_ASSERT_NEXT(a_result_follows, in_acc, m_tvalid)
    `PIDL_ASSERT_NEXT(a_reject_keeps_len, in_acc && !ok_next, count_reg == $past(count_reg))
    `PIDL_ASSERT_NOW(a_ins_room, cmd.insert, count_reg < cap_eff)

endmodule

// ----- sim/tb.sv -----
// testbench for the positional insert/delete list: directed and random list operations
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidl_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  length;
        logic              full;
    } list_reply_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = OP_READ;
    logic [39:0] s_tdata   = '0;   // position[3:0], value[35:4], zero pad
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // ok[0], read_value[32:1], length[37:33], full_res[38]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    logic [DATA_W-1:0] list_mem [DEPTH];
    int                list_len = 0;
    int                list_cap = DEPTH;
    list_reply_t       pending_replies [$];

    int mismatch_count   = 0;
    int ops_sent         = 0;
    int replies_seen     = 0;
    int cap_writes       = 0;
    int idle_cycles      = 0;
    int sink_hold_cycles = 0;
    bit src_idle_en      = 1'b1;
    bit sink_idle_en     = 1'b1;

    positional_insert_delete_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
            #1 clk = ~clk;
    end

    function automatic list_reply_t apply_list_op(input logic [1:0] op,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] val);
        list_reply_t r;
        int          lim;
        int          i;
        lim = (list_cap > DEPTH) ? DEPTH : list_cap;
        r.ok = 1'b0;
        r.read_value = '0;
        case (op)
            OP_INSERT:
                if (list_len < lim && pos <= list_len)
                begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            OP_REMOVE:
                if (pos < list_len)
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                    r.ok = 1'b1;
                end
            OP_READ:
                if (pos < list_len)
                begin
                    r.read_value = list_mem[pos];
                    r.ok = 1'b1;
                end
            OP_CLEAR:
            begin
                for (i = 0; i < list_len; i++)
                    list_mem[i] = '0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.length = list_len[CNT_W-1:0];
        r.full   = (list_len >= lim);
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want_v,
                                          input logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb: mismatch on %s at result %0d: expected %h, got %h",
                     what, replies_seen, want_v, got_v);
    endfunction

    task automatic send_list_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, val, pos};
        do
            @(posedge clk);
        while (!s_tready);
        pending_replies.push_back(apply_list_op(op, pos, val));
        ops_sent++;
    endtask

    task automatic finish_burst();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        finish_burst();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        list_cap = cap;
        cap_writes++;
    endtask

    // mostly positions inside the list, some anywhere
    task automatic random_list_op(input int insert_pct);
        logic [1:0]        op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int                pick;
        int                hi;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
            op = OP_INSERT;
        else
        begin
            pick = $urandom_range(0, 19);
            op = (pick == 0) ? OP_CLEAR : (pick < 10) ? OP_REMOVE : OP_READ;
        end
        hi = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;
        if ($urandom_range(0, 6) == 0)
            pos = POS_W'($urandom_range(0, DEPTH - 1));
        else
            pos = POS_W'($urandom_range(0, hi));
        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            default: val = $urandom;
        endcase
        send_list_op(op, pos, val);
    endtask

    task automatic test_empty_and_shift();
        int i;
        send_list_op(OP_READ,   0, $urandom);
        send_list_op(OP_REMOVE, 0, $urandom);
        send_list_op(OP_CLEAR,  POS_W'($urandom_range(0, 15)), $urandom);
        send_list_op(OP_INSERT, 1, 32'h1111_1111);
        send_list_op(OP_INSERT, 0, 32'h8000_0000);
        send_list_op(OP_INSERT, 1, 32'h7fff_ffff);
        send_list_op(OP_INSERT, 0, 32'hffff_ffff);
        send_list_op(OP_INSERT, 2, 32'h5a5a_5a5a);
        for (i = 0; i <= 4; i++)
            send_list_op(OP_READ, POS_W'(i), $urandom);
        send_list_op(OP_REMOVE, 1, $urandom);
        send_list_op(OP_READ,   1, $urandom);
        send_list_op(OP_REMOVE, 2, $urandom);
        send_list_op(OP_CLEAR,  15, $urandom);
        send_list_op(OP_READ,   0, $urandom);
        send_list_op(OP_READ,   15, $urandom);
        send_list_op(OP_REMOVE, 15, $urandom);
    endtask

    task automatic test_capacity_below_length();
        write_capacity(5'd4);
        send_list_op(OP_INSERT, 2, 32'h0000_0001);
        send_list_op(OP_INSERT, 0, 32'h1234_5678);
        send_list_op(OP_INSERT, 1, 32'h0bad_0bad);
        write_capacity(5'd2);
        send_list_op(OP_INSERT, 0, 32'h0000_0002);
        send_list_op(OP_READ,   3, $urandom);
        send_list_op(OP_REMOVE, 0, $urandom);
        send_list_op(OP_READ,   2, $urandom);
        send_list_op(OP_REMOVE, 2, $urandom);
        send_list_op(OP_INSERT, 2, 32'h0000_0003);
    endtask

    task automatic test_capacity_extremes();
        write_capacity(5'd0);
        send_list_op(OP_READ,   0, $urandom);
        send_list_op(OP_INSERT, 0, 32'h0000_0004);
        send_list_op(OP_REMOVE, 1, $urandom);
        send_list_op(OP_REMOVE, 0, $urandom);
        send_list_op(OP_CLEAR,  0, $urandom);
        write_capacity(5'd31);
        send_list_op(OP_INSERT, 0, 32'h0f0f_f0f0);
        send_list_op(OP_READ,   0, $urandom);
    endtask

    task automatic test_result_backpressure();
        write_capacity(5'd16);
        src_idle_en = 1'b0;
        sink_hold_cycles = 150;
        repeat (24) random_list_op(60);
        finish_burst();
        src_idle_en = 1'b1;
    endtask

    // each setting first favours inserts, then removes and reads
    task automatic test_random_phases();
        int caps [10] = '{16, 1, 7, 16, 31, 12, 0, 3, 16, 5};
        int p;
        for (p = 0; p < 10; p++)
        begin
            write_capacity(5'(caps[p]));
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            repeat (60) random_list_op(75);
            repeat (65) random_list_op(25);
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial
    begin : drain_results
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                gap = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            else
                gap = sink_idle_en ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_replies
        list_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
                note_mismatch("unexpected result", '0, 64'(m_tdata));
            else
            begin
                want = pending_replies.pop_front();
                if (m_tdata[0] !== want.ok)
                    note_mismatch("ok", 64'(want.ok), 64'(m_tdata[0]));
                if (m_tdata[32:1] !== want.read_value)
                    note_mismatch("read_value", 64'(want.read_value), 64'(m_tdata[32:1]));
                if (m_tdata[37:33] !== want.length)
                    note_mismatch("length", 64'(want.length), 64'(m_tdata[37:33]));
                if (m_tdata[38] !== want.full)
                    note_mismatch("full_res", 64'(want.full), 64'(m_tdata[38]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: no item moved for %0d cycles", idle_cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_shift();
        test_capacity_below_length();
        test_capacity_extremes();
        test_result_backpressure();
        test_random_phases();
        finish_burst();
        repeat (8) @(posedge clk);
        $display("tb: %0d list operations sent, %0d results checked, %0d mismatches",
                 ops_sent, replies_seen, mismatch_count);
        $display("tb: %0d capacity writes from 0 to 31, incl. a long result stall",
                 cap_writes);
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
